FILE: hdl/tpq_pkg.sv
// Package: item types, verdict codes and constants for the two-class priority queue.
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

  localparam int HANDLE_W = 16;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic CLASS_MGMT = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_SEND  = 3'd0,
    VERDICT_SCHED = 3'd1,
    VERDICT_DROP  = 3'd2,
    VERDICT_DEQ   = 3'd3,
    VERDICT_EMPTY = 3'd4
  } verdict_t;

  typedef struct packed {
    logic                mode;
    logic [HANDLE_W-1:0] handle;
    logic                is_management;
    logic                must_enqueue;
  } req_t;

  typedef struct packed {
    verdict_t            verdict;
    logic [HANDLE_W-1:0] handle_out;
    logic                from_management;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hdl/two_class_priority_queue.sv
// Top level: strict-priority management/data handle queues with tail drop.
//
//   port group   dir   handshake            payload
//   req          in    req_valid/req_stall  tpq_pkg::req_t (mode, handle, flags)
//   rsp          out   rsp_valid/rsp_stall  tpq_pkg::rsp_t (verdict, handle, class)
//
// One item per cycle while the result is not stalled; each accepted item passes
// the decision and RAM read stage, then the result register, before its result.
// Reset (rst, synchronous) empties both queues; stored handles are not cleared.
// A stalled result holds the whole pipeline; req_stall follows rsp_stall then.
`timescale 1ns / 1ps
`default_nettype none

module two_class_priority_queue #(
  parameter int DATA_DEPTH = 16,
  parameter int MGMT_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire tpq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output tpq_pkg::rsp_t      rsp
);

  localparam int MAW = $clog2(MGMT_DEPTH);
  localparam int MCW = $clog2(MGMT_DEPTH + 1);
  localparam int MSW = MCW + 1;
  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int DCW = $clog2(DATA_DEPTH + 1);
  localparam int DSW = DCW + 1;

  logic [MAW-1:0] mgmt_head, mgmt_head_next, mgmt_tail;
  logic [MCW-1:0] mgmt_count, mgmt_count_next;
  logic [MSW-1:0] mgmt_tail_sum;
  logic [DAW-1:0] data_head, data_head_next, data_tail;
  logic [DCW-1:0] data_count, data_count_next;
  logic [DSW-1:0] data_tail_sum;

  logic mgmt_empty, mgmt_full, data_empty, data_full;
  logic advance, accept;
  logic mgmt_wr, data_wr, mgmt_rd, data_rd;

  tpq_pkg::verdict_t verdict_next;
  logic              from_mgmt_next;

  logic              s1_valid;
  tpq_pkg::verdict_t s1_verdict;
  logic              s1_from_mgmt;

  logic [tpq_pkg::HANDLE_W-1:0] mgmt_q, data_q, s1_handle;

  assign advance   = !rsp_valid || !rsp_stall;
  assign accept    = req_valid && advance;
  assign req_stall = !advance;

  assign mgmt_empty = (mgmt_count == '0);
  assign mgmt_full  = (mgmt_count == MCW'(MGMT_DEPTH));
  assign data_empty = (data_count == '0);
  assign data_full  = (data_count == DCW'(DATA_DEPTH));

  assign mgmt_tail_sum = MSW'(mgmt_head) + MSW'(mgmt_count);
  assign mgmt_tail = (mgmt_tail_sum >= MSW'(MGMT_DEPTH)) ?
                     MAW'(mgmt_tail_sum - MSW'(MGMT_DEPTH)) : MAW'(mgmt_tail_sum);
  assign data_tail_sum = DSW'(data_head) + DSW'(data_count);
  assign data_tail = (data_tail_sum >= DSW'(DATA_DEPTH)) ?
                     DAW'(data_tail_sum - DSW'(DATA_DEPTH)) : DAW'(data_tail_sum);

  always_comb begin
    verdict_next    = tpq_pkg::VERDICT_EMPTY;
    from_mgmt_next  = 1'b0;
    mgmt_wr         = 1'b0;
    data_wr         = 1'b0;
    mgmt_rd         = 1'b0;
    data_rd         = 1'b0;
    mgmt_head_next  = mgmt_head;
    mgmt_count_next = mgmt_count;
    data_head_next  = data_head;
    data_count_next = data_count;
    if (req.mode == tpq_pkg::MODE_ENQ) begin
      if (req.is_management == tpq_pkg::CLASS_MGMT) begin
        if (!req.must_enqueue && mgmt_empty) begin
          verdict_next = tpq_pkg::VERDICT_SEND;
        end else if (mgmt_full) begin
          verdict_next = tpq_pkg::VERDICT_DROP;
        end else begin
          verdict_next    = tpq_pkg::VERDICT_SCHED;
          mgmt_wr         = 1'b1;
          mgmt_count_next = mgmt_count + MCW'(1);
        end
      end else begin
        if (!req.must_enqueue && data_empty) begin
          verdict_next = tpq_pkg::VERDICT_SEND;
        end else if (data_full) begin
          verdict_next = tpq_pkg::VERDICT_DROP;
        end else begin
          verdict_next    = tpq_pkg::VERDICT_SCHED;
          data_wr         = 1'b1;
          data_count_next = data_count + DCW'(1);
        end
      end
    end else if (!mgmt_empty) begin
      verdict_next    = tpq_pkg::VERDICT_DEQ;
      from_mgmt_next  = 1'b1;
      mgmt_rd         = 1'b1;
      mgmt_count_next = mgmt_count - MCW'(1);
      mgmt_head_next  = (mgmt_head == MAW'(MGMT_DEPTH - 1)) ? '0 : mgmt_head + MAW'(1);
    end else if (!data_empty) begin
      verdict_next    = tpq_pkg::VERDICT_DEQ;
      data_rd         = 1'b1;
      data_count_next = data_count - DCW'(1);
      data_head_next  = (data_head == DAW'(DATA_DEPTH - 1)) ? '0 : data_head + DAW'(1);
    end
  end

  tpq_ram #(.WIDTH(tpq_pkg::HANDLE_W), .DEPTH(MGMT_DEPTH)) u_mgmt_ram (
    .clk     (clk),
    .wr_en   (accept && mgmt_wr),
    .wr_addr (mgmt_tail),
    .wr_data (req.handle),
    .rd_en   (accept && mgmt_rd),
    .rd_addr (mgmt_head),
    .rd_data (mgmt_q)
  );

  tpq_ram #(.WIDTH(tpq_pkg::HANDLE_W), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk     (clk),
    .wr_en   (accept && data_wr),
    .wr_addr (data_tail),
    .wr_data (req.handle),
    .rd_en   (accept && data_rd),
    .rd_addr (data_head),
    .rd_data (data_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mgmt_head  <= '0;
      mgmt_count <= '0;
      data_head  <= '0;
      data_count <= '0;
    end else if (accept) begin
      mgmt_head  <= mgmt_head_next;
      mgmt_count <= mgmt_count_next;
      data_head  <= data_head_next;
      data_count <= data_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= req_valid;
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_verdict   <= verdict_next;
      s1_from_mgmt <= from_mgmt_next;
    end
  end

  assign s1_handle = (s1_verdict != tpq_pkg::VERDICT_DEQ) ? '0 :
                     (s1_from_mgmt ? mgmt_q : data_q);

  // Advance the result register when it is free or taken.
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      rsp.verdict         <= s1_verdict;
      rsp.handle_out      <= s1_handle;
      rsp.from_management <= s1_from_mgmt;
    end
  end

  a_mgmt_bound : assert property (@(posedge clk) disable iff (rst)
    mgmt_count <= MCW'(MGMT_DEPTH) && data_count <= DCW'(DATA_DEPTH))
    else $error("queue count beyond depth");

  a_mgmt_pop : assert property (@(posedge clk) disable iff (rst)
    accept && req.mode == tpq_pkg::MODE_DEQ && !mgmt_empty
    |=> mgmt_count == $past(mgmt_count) - MCW'(1) && data_count == $past(data_count))
    else $error("management pop did not update counts");

  a_no_handle : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.verdict != tpq_pkg::VERDICT_DEQ
    |-> rsp.handle_out == '0 && !rsp.from_management)
    else $error("handle reported without a dequeue");

  a_hold_pipe : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && s1_valid == $past(s1_valid))
    else $error("pipeline moved under stall");

endmodule

`default_nettype wire

FILE: hdl/tpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: tb/two_class_priority_queue_tb.sv
// Testbench: two-class priority queue checked against a built-in queue predictor.
`timescale 1ns / 1ps

module two_class_priority_queue_tb;

  localparam int DATA_DEPTH = 16;
  localparam int MGMT_DEPTH = 16;
  localparam int RANDOM_ITEMS = 760;
  localparam int STALL_LIMIT = 500;
  localparam int DRAIN_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  tpq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  tpq_pkg::rsp_t rsp;

  logic [tpq_pkg::HANDLE_W-1:0] mgmt_fifo[$];
  logic [tpq_pkg::HANDLE_W-1:0] data_fifo[$];
  tpq_pkg::rsp_t pending_rsp[$];

  int errors = 0;
  int rsp_count = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  two_class_priority_queue #(
    .DATA_DEPTH(DATA_DEPTH),
    .MGMT_DEPTH(MGMT_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int burst_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tpq_pkg::req_t make_req(logic mode,
                                             logic [tpq_pkg::HANDLE_W-1:0] handle,
                                             logic is_mgmt, logic force_q);
    tpq_pkg::req_t r;
    r.mode = mode;
    r.handle = handle;
    r.is_management = is_mgmt;
    r.must_enqueue = force_q;
    return r;
  endfunction

  function automatic tpq_pkg::rsp_t next_verdict(tpq_pkg::req_t r);
    tpq_pkg::rsp_t o;
    o = '0;
    if (r.mode == tpq_pkg::MODE_ENQ) begin
      if (r.is_management == tpq_pkg::CLASS_MGMT) begin
        if (!r.must_enqueue && mgmt_fifo.size() == 0) begin
          o.verdict = tpq_pkg::VERDICT_SEND;
        end else if (mgmt_fifo.size() >= MGMT_DEPTH) begin
          o.verdict = tpq_pkg::VERDICT_DROP;
        end else begin
          mgmt_fifo.push_back(r.handle);
          o.verdict = tpq_pkg::VERDICT_SCHED;
        end
      end else begin
        if (!r.must_enqueue && data_fifo.size() == 0) begin
          o.verdict = tpq_pkg::VERDICT_SEND;
        end else if (data_fifo.size() >= DATA_DEPTH) begin
          o.verdict = tpq_pkg::VERDICT_DROP;
        end else begin
          data_fifo.push_back(r.handle);
          o.verdict = tpq_pkg::VERDICT_SCHED;
        end
      end
    end else if (mgmt_fifo.size() > 0) begin
      o.verdict = tpq_pkg::VERDICT_DEQ;
      o.handle_out = mgmt_fifo.pop_front();
      o.from_management = 1'b1;
    end else if (data_fifo.size() > 0) begin
      o.verdict = tpq_pkg::VERDICT_DEQ;
      o.handle_out = data_fifo.pop_front();
    end else begin
      o.verdict = tpq_pkg::VERDICT_EMPTY;
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("ERROR: result %0d %s got %0h expected %0h", rsp_count, field, got, want);
    errors++;
  endtask

  task automatic send_item(tpq_pkg::req_t r);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : burst_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp.push_back(next_verdict(r));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      stall_left = burst_len() - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    tpq_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected verdict", rsp.verdict, 32'd0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.verdict !== want.verdict)
          report_mismatch("verdict", rsp.verdict, want.verdict);
        if (rsp.handle_out !== want.handle_out)
          report_mismatch("handle_out", rsp.handle_out, want.handle_out);
        if (rsp.from_management !== want.from_management)
          report_mismatch("from_management", rsp.from_management, want.from_management);
      end
      rsp_count++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_send_now();
    send_item(make_req(tpq_pkg::MODE_ENQ, 16'h0000, 1'b0, 1'b0));
    send_item(make_req(tpq_pkg::MODE_ENQ, 16'hFFFF, tpq_pkg::CLASS_MGMT, 1'b0));
    send_item(make_req(tpq_pkg::MODE_DEQ, 16'hFFFF, 1'b1, 1'b1));
  endtask

  task automatic test_forced_enqueue();
    send_item(make_req(tpq_pkg::MODE_ENQ, 16'hFFFF, 1'b0, 1'b1));
    send_item(make_req(tpq_pkg::MODE_ENQ, 16'h0000, tpq_pkg::CLASS_MGMT, 1'b1));
    send_item(make_req(tpq_pkg::MODE_ENQ, 16'h1234, 1'b0, 1'b0));
    send_item(make_req(tpq_pkg::MODE_ENQ, 16'hA5A5, tpq_pkg::CLASS_MGMT, 1'b0));
  endtask

  task automatic test_priority();
    repeat (5) send_item(make_req(tpq_pkg::MODE_DEQ, 16'h5A5A, 1'b0, 1'b0));
  endtask

  task automatic test_tail_drop();
    repeat (MGMT_DEPTH + 2)
      send_item(make_req(tpq_pkg::MODE_ENQ, 16'($urandom), tpq_pkg::CLASS_MGMT,
                         1'($urandom)));
    repeat (DATA_DEPTH + 2)
      send_item(make_req(tpq_pkg::MODE_ENQ, 16'($urandom), 1'b0, 1'($urandom)));
    repeat (MGMT_DEPTH + DATA_DEPTH + 2)
      send_item(make_req(tpq_pkg::MODE_DEQ, 16'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  task automatic test_random(int n);
    int sent;
    int burst;
    int enq_pct;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(20, 60);
      quiet = ($urandom_range(0, 99) < 20);
      case ($urandom_range(0, 2))
        0: begin
          enq_pct = 80;
        end
        1: begin
          enq_pct = 25;
        end
        default: begin
          enq_pct = 50;
        end
      endcase
      repeat (burst) begin
        if ($urandom_range(0, 99) < enq_pct)
          send_item(make_req(tpq_pkg::MODE_ENQ, 16'($urandom), 1'($urandom),
                             1'($urandom)));
        else
          send_item(make_req(tpq_pkg::MODE_DEQ, 16'($urandom), 1'($urandom),
                             1'($urandom)));
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_send_now();
    test_forced_enqueue();
    test_priority();
    test_tail_drop();
    test_random(RANDOM_ITEMS);
    req_valid <= 1'b0;
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
